FILE: hw/rtl/brld_pkg.sv
// Shared types, constants and the digit table of the bar code run-length decoder.
`default_nettype none

package brld_pkg;

  localparam int RUN_BITS_DEF = 8;
  localparam int NUM_RUNS = 31;
  localparam int RUNS_W = 5;
  localparam int Q_W = 3;

  localparam logic [Q_W-1:0] Q_NONE = 3'd5;

  localparam logic [Q_W-1:0] DIGIT_TABLE [10][3] = '{
    '{3'd2, 3'd1, 3'd1}, '{3'd2, 3'd2, 3'd1}, '{3'd1, 3'd2, 3'd2}, '{3'd4, 3'd1, 3'd1},
    '{3'd1, 3'd3, 3'd2}, '{3'd2, 3'd3, 3'd1}, '{3'd1, 3'd1, 3'd4}, '{3'd3, 3'd1, 3'd2},
    '{3'd2, 3'd1, 3'd3}, '{3'd1, 3'd1, 3'd2}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BITS,
    ST_ROW,
    ST_RD,
    ST_CLS,
    ST_ACC,
    ST_EMIT
  } brld_state_e;

  typedef enum logic [1:0] {
    RET_BITS,
    RET_ROW,
    RET_IDLE
  } brld_ret_e;

  typedef struct packed {
    logic accept;
    logic bit_step;
    logic row_step;
    logic cls;
    logic acc;
    logic emit;
  } brld_cmd_t;

  typedef struct packed {
    logic dec_req;
    logic bit_last;
    logic row_end;
    logic sub_last;
    logic dig_last;
    logic out_free;
  } brld_status_t;

  // The lowest matching row wins; no match gives digit zero.
  function automatic logic [3:0] digit_lookup(input logic [Q_W-1:0] a,
                                              input logic [Q_W-1:0] b,
                                              input logic [Q_W-1:0] c);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 9; k >= 0; k--) begin
      if (DIGIT_TABLE[k][0] == a && DIGIT_TABLE[k][1] == b && DIGIT_TABLE[k][2] == c) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/brld_ctrl.sv
// Controller state machine that sequences bit steps, row ends, decoding and result output.
`default_nettype none

module brld_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  brld_pkg::brld_status_t status_i,
  output brld_pkg::brld_cmd_t    cmd_o
);

  brld_pkg::brld_state_e state_q, state_d;
  brld_pkg::brld_ret_e   ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brld_pkg::ST_IDLE;
      ret_q   <= brld_pkg::RET_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      brld_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = brld_pkg::ST_BITS;
        end
      end
      brld_pkg::ST_BITS: begin
        if (status_i.dec_req) begin
          ret_d   = status_i.bit_last ? brld_pkg::RET_ROW : brld_pkg::RET_BITS;
          state_d = brld_pkg::ST_RD;
        end else if (status_i.bit_last) begin
          state_d = status_i.row_end ? brld_pkg::ST_ROW : brld_pkg::ST_IDLE;
        end
      end
      brld_pkg::ST_ROW: begin
        if (status_i.dec_req) begin
          ret_d   = brld_pkg::RET_IDLE;
          state_d = brld_pkg::ST_RD;
        end else begin
          state_d = brld_pkg::ST_IDLE;
        end
      end
      brld_pkg::ST_RD: begin
        state_d = brld_pkg::ST_CLS;
      end
      brld_pkg::ST_CLS: begin
        state_d = status_i.sub_last ? brld_pkg::ST_ACC : brld_pkg::ST_RD;
      end
      brld_pkg::ST_ACC: begin
        state_d = status_i.dig_last ? brld_pkg::ST_EMIT : brld_pkg::ST_RD;
      end
      brld_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          unique case (ret_q)
            brld_pkg::RET_BITS: state_d = brld_pkg::ST_BITS;
            brld_pkg::RET_ROW:  state_d = status_i.row_end ? brld_pkg::ST_ROW
                                                           : brld_pkg::ST_IDLE;
            default:            state_d = brld_pkg::ST_IDLE;
          endcase
        end
      end
      default: begin
        state_d = brld_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != brld_pkg::ST_IDLE);
    cmd_o           = '0;
    cmd_o.accept    = (state_q == brld_pkg::ST_IDLE) && in_valid_i;
    cmd_o.bit_step  = (state_q == brld_pkg::ST_BITS);
    cmd_o.row_step  = (state_q == brld_pkg::ST_ROW);
    cmd_o.cls       = (state_q == brld_pkg::ST_CLS);
    cmd_o.acc       = (state_q == brld_pkg::ST_ACC);
    cmd_o.emit      = (state_q == brld_pkg::ST_EMIT) && status_i.out_free;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/brld_datapath.sv
// Datapath with run measurement, the width store, width classification and digit accumulation.
`default_nettype none

module brld_datapath #(
  parameter int RUN_BITS = brld_pkg::RUN_BITS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire  [3:0]             nibble_i,
  input  wire                    row_end_i,
  input  brld_pkg::brld_cmd_t    cmd_i,
  output brld_pkg::brld_status_t status_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [31:0]            code_bcd_o,
  output logic [6:0]             digit_sum_o,
  output logic                   check_ok_o
);

  localparam int MW = RUN_BITS + 3;
  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;
  localparam logic [brld_pkg::RUNS_W-1:0] LAST_RUN = brld_pkg::RUNS_W'(brld_pkg::NUM_RUNS - 1);

  // Scan input and run measurement.
  logic [3:0]                    nib_q, nib_d;
  logic                          row_end_q, row_end_d;
  logic [1:0]                    bit_idx_q, bit_idx_d;
  logic                          emitted_q, emitted_d;
  logic                          level_q, level_d;
  logic                          capt_q, capt_d;
  logic [RUN_BITS-1:0]           run_len_q, run_len_d;
  logic [brld_pkg::RUNS_W-1:0]   runs_q, runs_d;
  logic [RUN_BITS-1:0]           min_q, min_d;
  logic                          cur_bit;
  logic                          dec_req;
  logic                          wr_en;

  logic [RUN_BITS-1:0]           widths [brld_pkg::NUM_RUNS];
  logic [RUN_BITS-1:0]           rd_data_q;

  // Decoding.
  logic [brld_pkg::RUNS_W-1:0]   rd_idx_q;
  logic [1:0]                    sub_q;
  logic [2:0]                    dig_q;
  logic [brld_pkg::Q_W-1:0]      q0_q, q1_q, q2_q;
  logic [brld_pkg::Q_W-1:0]      q_cls;
  logic [31:0]                   code_q;
  logic [6:0]                    sum_q;
  logic [3:0]                    res_q;
  logic [3:0]                    digit;
  logic [5:0]                    weighted;
  logic [5:0]                    res_sum;
  logic [3:0]                    res_next;
  logic [3:0]                    chk;
  logic [MW-1:0]                 m1, m2, m3, m4, m5, wx;

  function automatic logic [3:0] mod10(input logic [5:0] x);
    logic [5:0] r;
    if (x >= 6'd30) begin
      r = x - 6'd30;
    end else if (x >= 6'd20) begin
      r = x - 6'd20;
    end else if (x >= 6'd10) begin
      r = x - 6'd10;
    end else begin
      r = x;
    end
    return r[3:0];
  endfunction

  assign cur_bit = nib_q[2'd3 - bit_idx_q];

  always_comb begin
    nib_d     = nib_q;
    row_end_d = row_end_q;
    bit_idx_d = bit_idx_q;
    emitted_d = emitted_q;
    level_d   = level_q;
    capt_d    = capt_q;
    run_len_d = run_len_q;
    runs_d    = runs_q;
    min_d     = min_q;
    dec_req   = 1'b0;
    wr_en     = 1'b0;

    if (cmd_i.accept) begin
      nib_d     = nibble_i;
      row_end_d = row_end_i;
      bit_idx_d = 2'd0;
      emitted_d = 1'b0;
    end

    if (cmd_i.emit) begin
      emitted_d = 1'b1;
    end

    if (cmd_i.bit_step) begin
      bit_idx_d = bit_idx_q + 2'd1;
      if (capt_q) begin
        if (cur_bit == level_q) begin
          if (run_len_q != RUN_MAX) begin
            run_len_d = run_len_q + RUN_BITS'(1);
          end
        end else begin
          wr_en = 1'b1;
          if (run_len_q < min_q) begin
            min_d = run_len_q;
          end
          if (runs_q == LAST_RUN) begin
            // The closing bit is a space, so no new capture starts on it.
            dec_req   = 1'b1;
            capt_d    = 1'b0;
            runs_d    = '0;
            run_len_d = '0;
            level_d   = 1'b0;
          end else begin
            runs_d    = runs_q + brld_pkg::RUNS_W'(1);
            level_d   = cur_bit;
            run_len_d = RUN_BITS'(1);
          end
        end
      end else if (cur_bit) begin
        capt_d    = 1'b1;
        level_d   = 1'b1;
        run_len_d = RUN_BITS'(1);
        runs_d    = '0;
        min_d     = RUN_MAX;
      end
    end

    if (cmd_i.row_step && row_end_q) begin
      // A row end during the final bar closes it and completes the code.
      if (!emitted_q && capt_q && runs_q == LAST_RUN) begin
        wr_en   = 1'b1;
        dec_req = 1'b1;
        if (run_len_q < min_q) begin
          min_d = run_len_q;
        end
      end
      capt_d    = 1'b0;
      runs_d    = '0;
      run_len_d = '0;
      level_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_idx_q <= '0;
      emitted_q <= 1'b0;
      level_q   <= 1'b0;
      capt_q    <= 1'b0;
      run_len_q <= '0;
      runs_q    <= '0;
      min_q     <= RUN_MAX;
    end else begin
      bit_idx_q <= bit_idx_d;
      emitted_q <= emitted_d;
      level_q   <= level_d;
      capt_q    <= capt_d;
      run_len_q <= run_len_d;
      runs_q    <= runs_d;
      min_q     <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nib_q     <= nib_d;
    row_end_q <= row_end_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      widths[runs_q] <= run_len_q;
    end
    rd_data_q <= widths[rd_idx_q];
  end

  // The quotient by the smallest width only matters when it is one to four.
  always_comb begin
    m1 = MW'(min_q);
    m2 = m1 << 1;
    m3 = m1 + m2;
    m4 = m1 << 2;
    m5 = m4 + m1;
    wx = MW'(rd_data_q);
    if (min_q > RUN_BITS'(1)) begin
      if (wx < m1) begin
        q_cls = 3'd0;
      end else if (wx < m2) begin
        q_cls = 3'd1;
      end else if (wx < m3) begin
        q_cls = 3'd2;
      end else if (wx < m4) begin
        q_cls = 3'd3;
      end else if (wx < m5) begin
        q_cls = 3'd4;
      end else begin
        q_cls = brld_pkg::Q_NONE;
      end
    end else if (wx <= MW'(4)) begin
      q_cls = rd_data_q[2:0];
    end else begin
      q_cls = brld_pkg::Q_NONE;
    end
  end

  always_comb begin
    digit    = brld_pkg::digit_lookup(q0_q, q1_q, q2_q);
    if (dig_q == 3'd7) begin
      weighted = 6'd0;
    end else if (!dig_q[0]) begin
      weighted = {1'b0, digit, 1'b0} + {2'b00, digit};
    end else begin
      weighted = {2'b00, digit};
    end
    res_sum  = {2'b00, res_q} + weighted;
    res_next = mod10(res_sum);
    chk      = (res_q == 4'd0) ? 4'd0 : 4'd10 - res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      sub_q    <= '0;
      dig_q    <= '0;
    end else if (dec_req) begin
      rd_idx_q <= '0;
      sub_q    <= '0;
      dig_q    <= '0;
    end else begin
      if (cmd_i.cls) begin
        if (sub_q == 2'd2) begin
          sub_q    <= 2'd0;
          rd_idx_q <= rd_idx_q + brld_pkg::RUNS_W'(2);
        end else begin
          sub_q    <= sub_q + 2'd1;
          rd_idx_q <= rd_idx_q + brld_pkg::RUNS_W'(1);
        end
      end
      if (cmd_i.acc) begin
        dig_q <= dig_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_req) begin
      code_q <= '0;
      sum_q  <= '0;
      res_q  <= '0;
    end else if (cmd_i.acc) begin
      code_q <= {code_q[27:0], digit};
      sum_q  <= sum_q + {3'b000, digit};
      res_q  <= res_next;
    end
    if (cmd_i.cls) begin
      unique case (sub_q)
        2'd0:    q0_q <= q_cls;
        2'd1:    q1_q <= q_cls;
        default: q2_q <= q_cls;
      endcase
    end
  end

  // Output register; a result is loaded only when the previous one has gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      code_bcd_o  <= code_q;
      digit_sum_o <= sum_q;
      check_ok_o  <= (chk == code_q[3:0]);
    end
  end

  always_comb begin
    status_o          = '0;
    status_o.dec_req  = dec_req;
    status_o.bit_last = (bit_idx_q == 2'd3);
    status_o.row_end  = row_end_q;
    status_o.sub_last = (sub_q == 2'd2);
    status_o.dig_last = (dig_q == 3'd7);
    status_o.out_free = !out_valid_o;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/barcode_run_length_decoder.sv
// Top level of the bar code run-length decoder: controller, datapath and checks.
//
//   Channel | Direction | Handshake          | Payload
//   input   | in        | in_valid/in_stall  | nibble, row_end
//   output  | out       | out_valid/out_stall| code_bcd, digit_sum, check_ok
//
// A nibble is accepted in the idle state, then its four scan bits are stepped in turn,
// and a row-end step follows when it ends a row; decoding a code can come between.
// A completed code takes 24 width reads, each a read and a classify state, through the
// single read port of the width store, eight digit steps and the result-loading state.
// Loading waits while a previous result is still stalled in the output register.
// Reset clears the capture state; the width store needs no clearing.
`default_nettype none

module barcode_run_length_decoder #(
  parameter int RUN_BITS = brld_pkg::RUN_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [3:0]  nibble_i,
  input  wire         row_end_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] code_bcd_o,
  output logic [6:0]  digit_sum_o,
  output logic        check_ok_o
);

  brld_pkg::brld_cmd_t    cmd;
  brld_pkg::brld_status_t status;

  brld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  brld_datapath #(
    .RUN_BITS (RUN_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nibble_i    (nibble_i),
    .row_end_i   (row_end_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_bcd_o  (code_bcd_o),
    .digit_sum_o (digit_sum_o),
    .check_ok_o  (check_ok_o)
  );

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !out_valid_o)
    else $error("A result was loaded over one still waiting.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> in_stall_o)
    else $error("The block took a transaction without going busy.");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digit_sum_o <= 7'd72)
    else $error("Digit sum out of range.");

  a_bcd_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_bcd_o[31:28] <= 4'd9 && code_bcd_o[3:0] <= 4'd9))
    else $error("Result holds a non-decimal digit.");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the bar code run-length decoder.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned RUN_CAP = 255;
  localparam int unsigned RUN_COUNT = 31;
  localparam int unsigned NIBBLE_TARGET = 1300;
  localparam int unsigned QUIET_NIBBLES = 250;

  typedef struct packed {
    logic [31:0] code_bcd;
    logic [6:0]  digit_sum;
    logic        check_ok;
  } code_result_t;

  typedef enum int unsigned {
    FAULT_NONE,
    FAULT_WIDTH,
    FAULT_CUT,
    FAULT_LONG
  } line_fault_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [3:0]  nibble_i;
  logic        row_end_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] code_bcd_o;
  logic [6:0]  digit_sum_o;
  logic        check_ok_o;

  barcode_run_length_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .nibble_i    (nibble_i),
    .row_end_i   (row_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_bcd_o  (code_bcd_o),
    .digit_sum_o (digit_sum_o),
    .check_ok_o  (check_ok_o)
  );

  code_result_t expected_codes[$];

  int unsigned nibbles_sent = 0;
  int unsigned codes_checked = 0;
  int unsigned checks_passed = 0;
  int unsigned errors = 0;
  int unsigned idle_pct = 19;

  bit          scan_capturing = 1'b0;
  bit          scan_level = 1'b0;
  int unsigned scan_run_len = 0;
  int unsigned scan_runs_done = 0;
  int unsigned scan_min_width = RUN_CAP;
  int unsigned scan_widths [RUN_COUNT];

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [11:0] bar_pattern(input int unsigned digit);
    case (digit)
      0: return {4'd2, 4'd1, 4'd1};
      1: return {4'd2, 4'd2, 4'd1};
      2: return {4'd1, 4'd2, 4'd2};
      3: return {4'd4, 4'd1, 4'd1};
      4: return {4'd1, 4'd3, 4'd2};
      5: return {4'd2, 4'd3, 4'd1};
      6: return {4'd1, 4'd1, 4'd4};
      7: return {4'd3, 4'd1, 4'd2};
      8: return {4'd2, 4'd1, 4'd3};
      default: return {4'd1, 4'd1, 4'd2};
    endcase
  endfunction

  function automatic logic [3:0] weighted_check(input logic [31:0] code);
    int unsigned s;
    s = 0;
    for (int i = 0; i < 7; i++) begin
      s += (i % 2 == 0) ? 3 * code[31 - 4 * i -: 4] : code[31 - 4 * i -: 4];
    end
    return 4'((10 - s % 10) % 10);
  endfunction

  function automatic code_result_t decode_widths();
    code_result_t r;
    int unsigned q [RUN_COUNT];
    int unsigned d;
    int unsigned s;
    logic [11:0] pat;
    r = '0;
    s = 0;
    for (int i = 0; i < RUN_COUNT; i++) begin
      q[i] = (scan_min_width > 1) ? scan_widths[i] / scan_min_width : scan_widths[i];
    end
    for (int i = 0; i < 8; i++) begin
      d = 0;
      for (int k = 9; k >= 0; k--) begin
        pat = bar_pattern(k);
        if (pat[11:8] == q[4 * i] && pat[7:4] == q[4 * i + 1] && pat[3:0] == q[4 * i + 2]) begin
          d = k;
        end
      end
      r.code_bcd = {r.code_bcd[27:0], 4'(d)};
      r.digit_sum += 7'(d);
      if (i < 7) begin
        s += (i % 2 == 0) ? 3 * d : d;
      end else begin
        r.check_ok = ((10 - s % 10) % 10 == d);
      end
    end
    return r;
  endfunction

  function automatic void close_run();
    if (scan_runs_done < RUN_COUNT) begin
      scan_widths[scan_runs_done] = scan_run_len & RUN_CAP;
      if (scan_run_len < scan_min_width) begin
        scan_min_width = scan_run_len;
      end
    end
    scan_runs_done = (scan_runs_done + 1) & 31;
  endfunction

  function automatic void start_capture();
    scan_capturing = 1'b1;
    scan_level = 1'b1;
    scan_run_len = 1;
    scan_runs_done = 0;
    scan_min_width = RUN_CAP;
  endfunction

  function automatic void clear_capture();
    scan_capturing = 1'b0;
    scan_runs_done = 0;
    scan_run_len = 0;
    scan_level = 1'b0;
  endfunction

  function automatic bit scan_bit(input bit b, output code_result_t r);
    r = '0;
    if (scan_capturing) begin
      if (b == scan_level) begin
        if (scan_run_len < RUN_CAP) begin
          scan_run_len++;
        end
        return 1'b0;
      end
      close_run();
      if (scan_runs_done >= RUN_COUNT) begin
        r = decode_widths();
        clear_capture();
        if (b) begin
          start_capture();
        end
        return 1'b1;
      end
      scan_level = b;
      scan_run_len = 1;
      return 1'b0;
    end
    if (b) begin
      start_capture();
    end
    return 1'b0;
  endfunction

  function automatic void predict_scan_nibble(input logic [3:0] nib, input logic last);
    code_result_t r;
    code_result_t found;
    bit emitted;
    emitted = 1'b0;
    found = '0;
    for (int k = 3; k >= 0; k--) begin
      if (scan_bit(nib[k], r)) begin
        emitted = 1'b1;
        found = r;
      end
    end
    if (last) begin
      if (!emitted && scan_capturing && scan_runs_done == RUN_COUNT - 1) begin
        close_run();
        found = decode_widths();
        emitted = 1'b1;
      end
      clear_capture();
    end
    if (emitted) begin
      expected_codes.push_back(found);
    end
  endfunction

  task automatic send_nibble(input logic [3:0] nib, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    nibble_i <= nib;
    row_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_scan_nibble(nib, last);
    nibbles_sent++;
  endtask

  task automatic send_scan(input bit scan[$], input bit close_row);
    int unsigned count;
    count = scan.size() / 4;
    for (int k = 0; k < count; k++) begin
      send_nibble({scan[4 * k], scan[4 * k + 1], scan[4 * k + 2], scan[4 * k + 3]},
                  close_row && (k == count - 1));
    end
  endtask

  task automatic send_code(input logic [31:0] code, input int unsigned unit_w,
                           input bit end_on_row, input line_fault_e fault);
    int unsigned widths [RUN_COUNT];
    bit scan[$];
    logic [11:0] pat;
    int unsigned idx;
    int unsigned cut;
    bit close_row;
    for (int i = 0; i < 8; i++) begin
      pat = bar_pattern(code[31 - 4 * i -: 4]);
      widths[4 * i] = pat[11:8] * unit_w;
      widths[4 * i + 1] = pat[7:4] * unit_w;
      widths[4 * i + 2] = pat[3:0] * unit_w;
      if (i < 7) begin
        widths[4 * i + 3] = unit_w * $urandom_range(1, 3);
      end
    end
    idx = $urandom_range(RUN_COUNT - 1);
    if (fault == FAULT_WIDTH) begin
      widths[idx] = (widths[idx] > 1 && $urandom_range(1)) ? widths[idx] - 1 : widths[idx] + 1;
    end else if (fault == FAULT_LONG) begin
      widths[idx] = $urandom_range(256, 300);
    end
    repeat ($urandom_range(0, 6)) scan.push_back(1'b0);
    for (int r = 0; r < RUN_COUNT; r++) begin
      repeat (widths[r]) scan.push_back(r % 2 == 0);
    end
    if (fault == FAULT_CUT) begin
      cut = $urandom_range(1, scan.size() - 1);
      scan = scan[0:cut - 1];
      while (scan.size() % 4 != 0) scan.push_back($urandom_range(1));
      close_row = 1'b1;
    end else if (end_on_row) begin
      while (scan.size() % 4 != 0) scan.push_front(1'b0);
      close_row = 1'b1;
    end else begin
      scan.push_back(1'b0);
      while (scan.size() % 4 != 0) scan.push_back(1'b0);
      close_row = $urandom_range(1);
    end
    send_scan(scan, close_row);
  endtask

  function automatic logic [31:0] random_code();
    logic [31:0] code;
    code = '0;
    for (int i = 0; i < 7; i++) begin
      code[31 - 4 * i -: 4] = 4'($urandom_range(9));
    end
    code[3:0] = $urandom_range(1) ? weighted_check(code) : 4'($urandom_range(9));
    return code;
  endfunction

  task automatic test_field_extremes();
    send_nibble(4'h0, 1'b0);
    send_nibble(4'hF, 1'b1);
    send_nibble(4'h8, 1'b0);
    send_nibble(4'h1, 1'b1);
    send_nibble(4'hA, 1'b0);
    send_nibble(4'h5, 1'b1);
  endtask

  task automatic test_all_digits();
    send_code({28'h0123456, weighted_check(32'h01234560)}, 1, 1'b0, FAULT_NONE);
    send_code(32'h78901234, 1, 1'b0, FAULT_NONE);
  endtask

  task automatic test_check_remainder_zero();
    send_code(32'h00000000, 1, 1'b0, FAULT_NONE);
    send_code(32'h50500000, 1, 1'b0, FAULT_NONE);
  endtask

  task automatic test_row_end_final_bar();
    send_code(random_code(), 1, 1'b1, FAULT_NONE);
    send_code(random_code(), 2, 1'b1, FAULT_NONE);
  endtask

  task automatic test_scaled_widths();
    send_code(random_code(), 3, 1'b0, FAULT_NONE);
    send_code(random_code(), 16, 1'b0, FAULT_NONE);
  endtask

  task automatic test_broken_lines();
    send_code(random_code(), 1, 1'b0, FAULT_WIDTH);
    send_code(random_code(), 1, 1'b0, FAULT_CUT);
    send_code(random_code(), 1, 1'b0, FAULT_LONG);
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned unit_w;
    int unsigned quiet_end;
    quiet_end = nibbles_sent + QUIET_NIBBLES;
    idle_pct = 0;
    while (nibbles_sent < NIBBLE_TARGET) begin
      if (nibbles_sent >= quiet_end) begin
        idle_pct = 19;
      end
      pick = $urandom_range(99);
      if ($urandom_range(24) == 0) begin
        unit_w = $urandom_range(4, 12);
      end else begin
        unit_w = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
      end
      if (pick < 70) begin
        send_code(random_code(), unit_w, $urandom_range(3) == 0, FAULT_NONE);
      end else if (pick < 78) begin
        send_code(random_code(), unit_w, 1'b0, FAULT_WIDTH);
      end else if (pick < 86) begin
        send_code(random_code(), unit_w, 1'b0, FAULT_CUT);
      end else if (pick < 88) begin
        send_code(random_code(), 1, 1'b0, FAULT_LONG);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_nibble(4'($urandom_range(15)), $urandom_range(3) == 0);
        end
      end
    end
    idle_pct = 19;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk_i) begin
    code_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_codes.size() == 0) begin
        $error("Unexpected result: code_bcd %h, digit_sum %0d, check_ok %0d",
               code_bcd_o, digit_sum_o, check_ok_o);
        errors++;
      end else begin
        want = expected_codes.pop_front();
        codes_checked++;
        if (want.check_ok) begin
          checks_passed++;
        end
        if (code_bcd_o !== want.code_bcd) begin
          $error("code_bcd: expected %h, actual %h", want.code_bcd, code_bcd_o);
          errors++;
        end
        if (digit_sum_o !== want.digit_sum) begin
          $error("digit_sum: expected %0d, actual %0d", want.digit_sum, digit_sum_o);
          errors++;
        end
        if (check_ok_o !== want.check_ok) begin
          $error("check_ok: expected %0d, actual %0d", want.check_ok, check_ok_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    nibble_i = 4'h0;
    row_end_i = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_field_extremes();
    test_all_digits();
    test_check_remainder_zero();
    test_row_end_final_bar();
    test_scaled_widths();
    test_broken_lines();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (expected_codes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
    $display("Sent %0d scan nibbles, covering clean, scaled, damaged and saturated lines.",
             nibbles_sent);
    $display("Checked %0d decoded codes, %0d of them with a passing check digit.",
             codes_checked, checks_passed);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
